>>> design/nbe_pkg.sv
package nbe_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFTENING_SQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONSTANT = 2'd2;

  localparam logic [31:0] TIME_STEP_RST = 32'd656;
  localparam logic [31:0] SOFTENING_SQ_RST = 32'd0;
  localparam logic [31:0] GRAV_CONSTANT_RST = 32'd65536;

  typedef struct packed {
    logic [31:0]        body_mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               last_particle;
  } nbe_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [5:0]         particle_index;
    logic               last_result;
    logic               overflow;
  } nbe_out_t;

  typedef struct packed {
    logic [31:0]        mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } ram_word_t;

  localparam int RAM_W = $bits(ram_word_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDI,
    ST_LATI,
    ST_RDJ,
    ST_LATJ,
    ST_MLO,
    ST_MHI,
    ST_MSUM,
    ST_MUSE,
    ST_R2CHK,
    ST_SQRT,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MOP_SQ,
    MOP_R3,
    MOP_GM,
    MOP_TERM,
    MOP_EPOS,
    MOP_EVEL
  } mop_e;

endpackage

>>> design/direct_nbody_euler_step_core.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_item_i (nbe_in_t)
// out      output     out_valid_o / out_ready_i out_item_o (nbe_out_t)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Load items are taken back to back while the core is idle. An item marked last starts the
// step, which reads the particle memory once per particle and once per pair; each pair with a
// nonzero softened squared distance waits on the square root and the divider, and each particle
// then runs the Euler update. Loads are refused until the step ends.
// Reset clears the counters and flags and sets the configuration registers to their defaults.
// A stalled result holds the sequencer only at the point of handing over the next result.
module direct_nbody_euler_step_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  nbe_pkg::nbe_in_t                   in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output nbe_pkg::nbe_out_t                  out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nbe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  localparam logic signed [64:0] ACC_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INC_CAP = 64'h100_0000_0000;

  nbe_pkg::state_e state_q, state_d;
  nbe_pkg::mop_e   op_q;

  logic [31:0] dt_q, eps_q, g_q;
  logic [nbe_pkg::CNT_W-1:0] cnt_q, i_q, j_q;
  logic dropped_q;
  logic [1:0] k_q;

  logic in_acc, ram_we, out_free, j_eq_n, j_eq_i, i_last;
  logic [nbe_pkg::IDX_W-1:0] ram_raddr;
  nbe_pkg::ram_word_t ram_wdata, ram_rdata;

  logic signed [31:0] pos_i_q [3];
  logic signed [31:0] vel_i_q [3];
  logic signed [31:0] newp_q [3];
  logic signed [31:0] newv_q [3];
  logic signed [63:0] acc_q [3];
  logic [31:0] ad_q [3];
  logic        dneg_q [3];
  logic [31:0] mj_q;
  logic [49:0] r2_q;
  logic [63:0] r3_q, f_q;
  logic [63:0] mul_a_q, p_q, lo_q, mq_q;
  logic [31:0] mul_b_q;
  logic        eneg_q;

  logic signed [31:0] rd_pos [3];
  logic signed [32:0] dd [3];
  logic [31:0] ad_c [3];
  logic [95:0] full;
  logic [63:0] mq_c;
  logic [47:0] r2s;
  logic sqrt_start, sqrt_done, div_start, div_done;
  logic [31:0] sqrt_root;
  logic [63:0] div_quo;
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_nx;
  logic [63:0] mcap;
  logic signed [31:0] eul_old, eul_c;
  logic [40:0] inc41;
  logic signed [42:0] s43;
  logic out_valid_q;
  nbe_pkg::nbe_out_t out_q;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
    sext32 = {{32{v[31]}}, v};
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_acc   = in_valid_i && in_ready_o;
  assign ram_we   = in_acc && (cnt_q < nbe_pkg::CNT_W'(nbe_pkg::MAX_PARTICLES));
  assign out_free = !out_valid_q || out_ready_i;
  assign j_eq_n   = (j_q == cnt_q);
  assign j_eq_i   = (j_q == i_q);
  assign i_last   = (i_q == cnt_q - nbe_pkg::CNT_W'(1));

  always_comb begin
    ram_wdata.mass  = in_item_i.body_mass;
    ram_wdata.pos_x = in_item_i.pos_x;
    ram_wdata.pos_y = in_item_i.pos_y;
    ram_wdata.pos_z = in_item_i.pos_z;
    ram_wdata.vel_x = in_item_i.vel_x;
    ram_wdata.vel_y = in_item_i.vel_y;
    ram_wdata.vel_z = in_item_i.vel_z;
  end

  nbe_ram #(
    .WIDTH(nbe_pkg::RAM_W),
    .DEPTH(nbe_pkg::MAX_PARTICLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[nbe_pkg::IDX_W-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_pos[0] = ram_rdata.pos_x;
  assign rd_pos[1] = ram_rdata.pos_y;
  assign rd_pos[2] = ram_rdata.pos_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dd[a]   = {rd_pos[a][31], rd_pos[a]} - {pos_i_q[a][31], pos_i_q[a]};
      ad_c[a] = dd[a][32] ? 32'(-dd[a]) : dd[a][31:0];
    end
  end

  assign full = {p_q, 32'h0} + {32'h0, lo_q};
  assign mq_c = (|full[95:80]) ? '1 : full[79:16];
  assign r2s  = (r2_q > 50'h0_FFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : r2_q[47:0];

  always_comb begin
    mcap = mq_q[63] ? 64'h7FFF_FFFF_FFFF_FFFF : mq_q;
    if (dneg_q[k_q]) begin
      acc_sum = {acc_q[k_q][63], acc_q[k_q]} - $signed({1'b0, mcap});
      acc_nx  = (acc_sum < -ACC_MAX) ? 64'(-ACC_MAX) : acc_sum[63:0];
    end else begin
      acc_sum = {acc_q[k_q][63], acc_q[k_q]} + $signed({1'b0, mcap});
      acc_nx  = (acc_sum > ACC_MAX) ? 64'(ACC_MAX) : acc_sum[63:0];
    end
  end

  always_comb begin
    eul_old = (op_q == nbe_pkg::MOP_EPOS) ? pos_i_q[k_q] : vel_i_q[k_q];
    inc41   = (mq_q > INC_CAP) ? INC_CAP[40:0] : mq_q[40:0];
    if (eneg_q) begin
      s43 = {{11{eul_old[31]}}, eul_old} - $signed({2'b0, inc41});
    end else begin
      s43 = {{11{eul_old[31]}}, eul_old} + $signed({2'b0, inc41});
    end
    if (s43 > 43'sh7FFF_FFFF) begin
      eul_c = 32'sh7FFF_FFFF;
    end else if (s43 < -43'sh8000_0000) begin
      eul_c = 32'sh8000_0000;
    end else begin
      eul_c = s43[31:0];
    end
  end

  nbe_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .radicand_i({r2s, 16'h0}),
    .done_o    (sqrt_done),
    .root_o    (sqrt_root)
  );

  nbe_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({mq_q[47:0], 16'h0}),
    .divisor_i (r3_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nbe_pkg::ST_IDLE:  if (in_acc && in_item_i.last_particle) state_d = nbe_pkg::ST_RDI;
      nbe_pkg::ST_RDI:   state_d = nbe_pkg::ST_LATI;
      nbe_pkg::ST_LATI:  state_d = nbe_pkg::ST_RDJ;
      nbe_pkg::ST_RDJ: begin
        if (j_eq_n) begin
          state_d = nbe_pkg::ST_MLO;
        end else if (!j_eq_i) begin
          state_d = nbe_pkg::ST_LATJ;
        end
      end
      nbe_pkg::ST_LATJ:  state_d = nbe_pkg::ST_MLO;
      nbe_pkg::ST_MLO:   state_d = nbe_pkg::ST_MHI;
      nbe_pkg::ST_MHI:   state_d = nbe_pkg::ST_MSUM;
      nbe_pkg::ST_MSUM:  state_d = nbe_pkg::ST_MUSE;
      nbe_pkg::ST_MUSE: begin
        unique case (op_q)
          nbe_pkg::MOP_SQ:   state_d = (k_q < 2'd2) ? nbe_pkg::ST_MLO : nbe_pkg::ST_R2CHK;
          nbe_pkg::MOP_R3:   state_d = nbe_pkg::ST_MLO;
          nbe_pkg::MOP_GM:   state_d = nbe_pkg::ST_DIV;
          nbe_pkg::MOP_TERM: state_d = (k_q < 2'd2) ? nbe_pkg::ST_MLO : nbe_pkg::ST_RDJ;
          nbe_pkg::MOP_EPOS: state_d = nbe_pkg::ST_MLO;
          nbe_pkg::MOP_EVEL: state_d = (k_q < 2'd2) ? nbe_pkg::ST_MLO : nbe_pkg::ST_EMIT;
          default:           state_d = nbe_pkg::ST_IDLE;
        endcase
      end
      nbe_pkg::ST_R2CHK: state_d = (r2s == 48'd0) ? nbe_pkg::ST_RDJ : nbe_pkg::ST_SQRT;
      nbe_pkg::ST_SQRT:  if (sqrt_done) state_d = nbe_pkg::ST_MLO;
      nbe_pkg::ST_DIV:   if (div_done) state_d = nbe_pkg::ST_MLO;
      nbe_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = i_last ? nbe_pkg::ST_IDLE : nbe_pkg::ST_RDI;
        end
      end
      default: state_d = nbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == nbe_pkg::ST_IDLE);
    ram_raddr  = (state_q == nbe_pkg::ST_RDI) ? i_q[nbe_pkg::IDX_W-1:0]
                                              : j_q[nbe_pkg::IDX_W-1:0];
    sqrt_start = (state_q == nbe_pkg::ST_R2CHK) && (r2s != 48'd0);
    div_start  = (state_q == nbe_pkg::ST_MUSE) && (op_q == nbe_pkg::MOP_GM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nbe_pkg::ST_IDLE;
      op_q      <= nbe_pkg::MOP_SQ;
      k_q       <= 2'd0;
      cnt_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      dropped_q <= 1'b0;
      dt_q      <= nbe_pkg::TIME_STEP_RST;
      eps_q     <= nbe_pkg::SOFTENING_SQ_RST;
      g_q       <= nbe_pkg::GRAV_CONSTANT_RST;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          nbe_pkg::CFG_TIME_STEP:     dt_q  <= cfg_data_i;
          nbe_pkg::CFG_SOFTENING_SQ:  eps_q <= cfg_data_i;
          nbe_pkg::CFG_GRAV_CONSTANT: g_q   <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        nbe_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (ram_we) begin
              cnt_q <= cnt_q + nbe_pkg::CNT_W'(1);
            end else begin
              dropped_q <= 1'b1;
            end
            if (in_item_i.last_particle) i_q <= '0;
          end
        end
        nbe_pkg::ST_LATI: j_q <= '0;
        nbe_pkg::ST_RDJ: begin
          if (j_eq_n) begin
            k_q  <= 2'd0;
            op_q <= nbe_pkg::MOP_EPOS;
          end else if (j_eq_i) begin
            j_q <= j_q + nbe_pkg::CNT_W'(1);
          end
        end
        nbe_pkg::ST_LATJ: begin
          k_q  <= 2'd0;
          op_q <= nbe_pkg::MOP_SQ;
        end
        nbe_pkg::ST_MUSE: begin
          unique case (op_q)
            nbe_pkg::MOP_SQ: if (k_q < 2'd2) k_q <= k_q + 2'd1;
            nbe_pkg::MOP_R3: op_q <= nbe_pkg::MOP_GM;
            nbe_pkg::MOP_GM: ;
            nbe_pkg::MOP_TERM: begin
              if (k_q < 2'd2) begin
                k_q <= k_q + 2'd1;
              end else begin
                j_q <= j_q + nbe_pkg::CNT_W'(1);
              end
            end
            nbe_pkg::MOP_EPOS: begin
              if (k_q < 2'd2) begin
                k_q <= k_q + 2'd1;
              end else begin
                k_q  <= 2'd0;
                op_q <= nbe_pkg::MOP_EVEL;
              end
            end
            nbe_pkg::MOP_EVEL: if (k_q < 2'd2) k_q <= k_q + 2'd1;
            default: ;
          endcase
        end
        nbe_pkg::ST_R2CHK: if (r2s == 48'd0) j_q <= j_q + nbe_pkg::CNT_W'(1);
        nbe_pkg::ST_SQRT:  if (sqrt_done) op_q <= nbe_pkg::MOP_R3;
        nbe_pkg::ST_DIV: begin
          if (div_done) begin
            k_q  <= 2'd0;
            op_q <= nbe_pkg::MOP_TERM;
          end
        end
        nbe_pkg::ST_EMIT: begin
          if (out_free) begin
            if (i_last) begin
              cnt_q     <= '0;
              dropped_q <= 1'b0;
            end else begin
              i_q <= i_q + nbe_pkg::CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      nbe_pkg::ST_LATI: begin
        pos_i_q[0] <= ram_rdata.pos_x;
        pos_i_q[1] <= ram_rdata.pos_y;
        pos_i_q[2] <= ram_rdata.pos_z;
        vel_i_q[0] <= ram_rdata.vel_x;
        vel_i_q[1] <= ram_rdata.vel_y;
        vel_i_q[2] <= ram_rdata.vel_z;
        for (int a = 0; a < 3; a++) acc_q[a] <= 64'sd0;
      end
      nbe_pkg::ST_RDJ: begin
        if (j_eq_n) begin
          mul_a_q <= mag64(sext32(vel_i_q[0]));
          mul_b_q <= dt_q;
          eneg_q  <= vel_i_q[0][31];
        end
      end
      nbe_pkg::ST_LATJ: begin
        for (int a = 0; a < 3; a++) begin
          ad_q[a]   <= ad_c[a];
          dneg_q[a] <= dd[a][32];
        end
        mj_q    <= ram_rdata.mass;
        r2_q    <= {18'h0, eps_q};
        mul_a_q <= {32'h0, ad_c[0]};
        mul_b_q <= ad_c[0];
      end
      nbe_pkg::ST_MLO: p_q <= mul_a_q[31:0] * mul_b_q;
      nbe_pkg::ST_MHI: begin
        lo_q <= p_q;
        p_q  <= mul_a_q[63:32] * mul_b_q;
      end
      nbe_pkg::ST_MSUM: mq_q <= mq_c;
      nbe_pkg::ST_MUSE: begin
        unique case (op_q)
          nbe_pkg::MOP_SQ: begin
            r2_q <= r2_q + {2'b0, mq_q[47:0]};
            if (k_q < 2'd2) begin
              mul_a_q <= {32'h0, ad_q[k_q + 2'd1]};
              mul_b_q <= ad_q[k_q + 2'd1];
            end
          end
          nbe_pkg::MOP_R3: begin
            r3_q    <= (mq_q == 64'd0) ? 64'd1 : mq_q;
            mul_a_q <= {32'h0, g_q};
            mul_b_q <= mj_q;
          end
          nbe_pkg::MOP_GM: ;
          nbe_pkg::MOP_TERM: begin
            acc_q[k_q] <= acc_nx;
            if (k_q < 2'd2) begin
              mul_a_q <= f_q;
              mul_b_q <= ad_q[k_q + 2'd1];
            end
          end
          nbe_pkg::MOP_EPOS: begin
            newp_q[k_q] <= eul_c;
            if (k_q < 2'd2) begin
              mul_a_q <= mag64(sext32(vel_i_q[k_q + 2'd1]));
              eneg_q  <= vel_i_q[k_q + 2'd1][31];
            end else begin
              mul_a_q <= mag64(acc_q[0]);
              eneg_q  <= acc_q[0][63];
            end
          end
          nbe_pkg::MOP_EVEL: begin
            newv_q[k_q] <= eul_c;
            if (k_q < 2'd2) begin
              mul_a_q <= mag64(acc_q[k_q + 2'd1]);
              eneg_q  <= acc_q[k_q + 2'd1][63];
            end
          end
          default: ;
        endcase
      end
      nbe_pkg::ST_R2CHK: r2_q <= {2'b0, r2s};
      nbe_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          mul_a_q <= {16'h0, r2_q[47:0]};
          mul_b_q <= sqrt_root;
        end
      end
      nbe_pkg::ST_DIV: begin
        if (div_done) begin
          f_q     <= div_quo;
          mul_a_q <= div_quo;
          mul_b_q <= ad_q[0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == nbe_pkg::ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == nbe_pkg::ST_EMIT && out_free) begin
      out_q.new_pos_x      <= newp_q[0];
      out_q.new_pos_y      <= newp_q[1];
      out_q.new_pos_z      <= newp_q[2];
      out_q.new_vel_x      <= newv_q[0];
      out_q.new_vel_y      <= newv_q[1];
      out_q.new_vel_z      <= newv_q[2];
      out_q.particle_index <= 6'(i_q);
      out_q.last_result    <= i_last;
      out_q.overflow       <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= nbe_pkg::CNT_W'(nbe_pkg::MAX_PARTICLES))
    else $error("Loaded count exceeds the store depth.");

  a_pair_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nbe_pkg::ST_LATJ) |-> (j_q < cnt_q && j_q != i_q))
    else $error("Pair read outside the loaded set or of the particle itself.");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == nbe_pkg::ST_EMIT))
    else $error("Result item raised outside the hand-over state.");

endmodule

>>> design/nbe_ram.sv
module nbe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/nbe_isqrt.sv
module nbe_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] v_q, res_q, bitpos_q;
  logic        run_q, done_q;
  logic [63:0] trial;

  assign trial = res_q + bitpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && bitpos_q == 64'd1) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q      <= radicand_i;
      res_q    <= 64'd0;
      bitpos_q <= 64'd1 << 62;
    end else if (run_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bitpos_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bitpos_q <= bitpos_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

>>> design/nbe_div.sv
module nbe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [63:0] rem_q, quo_q, div_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  logic [64:0] trial;
  logic        take;

  assign trial = {rem_q, quo_q[63]};
  assign take  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 64'd0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= take ? 64'(trial - {1'b0, div_q}) : trial[63:0];
      quo_q <= {quo_q[62:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> verif/nbe_step_checker.sv
module nbe_step_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  nbe_pkg::nbe_in_t              in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  nbe_pkg::nbe_out_t             out_item_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [nbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned R2_LIMIT = 64'hFFFF_FFFF_FFFF;
  localparam longint INC_LIMIT = 64'h100_0000_0000;
  localparam longint ACC_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [31:0]        dt_q;
  logic [31:0]        eps_sq_q;
  logic [31:0]        grav_q;
  logic [31:0]        mass_mem [nbe_pkg::MAX_PARTICLES];
  logic signed [31:0] pos_mem [nbe_pkg::MAX_PARTICLES][3];
  logic signed [31:0] vel_mem [nbe_pkg::MAX_PARTICLES][3];
  int                 body_count;
  logic               dropped;
  nbe_pkg::nbe_out_t  expected_q[$];
  int                 fail_count;

  assign fail_count_o = fail_count;
  assign pending_o = expected_q.size();

  function automatic longint unsigned mul_q16(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:80] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return p[79:16];
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic longint add_sat(longint acc, longint unsigned mag, bit neg);
    longint m;
    m = (mag > longint'(ACC_LIMIT)) ? ACC_LIMIT : longint'(mag);
    if (!neg) return (acc > ACC_LIMIT - m) ? ACC_LIMIT : acc + m;
    return (acc < -ACC_LIMIT + m) ? -ACC_LIMIT : acc - m;
  endfunction

  function automatic logic signed [31:0] advance(longint old, longint val);
    longint unsigned mag, p;
    longint inc, s;
    mag = (val < 0) ? longint'(0) - val : val;
    p = mul_q16(mag, {32'd0, dt_q});
    inc = (p > longint'(INC_LIMIT)) ? INC_LIMIT : longint'(p);
    s = (val < 0) ? old - inc : old + inc;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  task automatic predict_step();
    longint            acc [3];
    longint            d [3];
    longint unsigned   ad [3];
    longint unsigned   r2, r, r3, gm, f;
    nbe_pkg::nbe_out_t res;
    for (int i = 0; i < body_count; i++) begin
      for (int k = 0; k < 3; k++) acc[k] = 0;
      for (int j = 0; j < body_count; j++) begin
        if (j == i) continue;
        r2 = eps_sq_q;
        for (int k = 0; k < 3; k++) begin
          d[k] = longint'(pos_mem[j][k]) - longint'(pos_mem[i][k]);
          ad[k] = (d[k] < 0) ? -d[k] : d[k];
          r2 = r2 + ((ad[k] * ad[k]) >> 16);
        end
        if (r2 > R2_LIMIT) r2 = R2_LIMIT;
        if (r2 == 0) continue;
        r = root64(r2 << 16);
        r3 = mul_q16(r2, r);
        if (r3 == 0) r3 = 1;
        gm = mul_q16({32'd0, grav_q}, {32'd0, mass_mem[j]});
        f = (gm << 16) / r3;
        for (int k = 0; k < 3; k++) acc[k] = add_sat(acc[k], mul_q16(f, ad[k]), d[k] < 0);
      end
      res.new_pos_x = advance(pos_mem[i][0], vel_mem[i][0]);
      res.new_pos_y = advance(pos_mem[i][1], vel_mem[i][1]);
      res.new_pos_z = advance(pos_mem[i][2], vel_mem[i][2]);
      res.new_vel_x = advance(vel_mem[i][0], acc[0]);
      res.new_vel_y = advance(vel_mem[i][1], acc[1]);
      res.new_vel_z = advance(vel_mem[i][2], acc[2]);
      res.particle_index = i[5:0];
      res.last_result = (i + 1 == body_count);
      res.overflow = dropped;
      expected_q.push_back(res);
    end
    body_count = 0;
    dropped = 0;
  endtask

  task automatic compare_result(nbe_pkg::nbe_out_t got);
    nbe_pkg::nbe_out_t want;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result %h", got);
      return;
    end
    want = expected_q.pop_front();
    if (got.new_pos_x !== want.new_pos_x || got.new_pos_y !== want.new_pos_y ||
        got.new_pos_z !== want.new_pos_z || got.new_vel_x !== want.new_vel_x ||
        got.new_vel_y !== want.new_vel_y || got.new_vel_z !== want.new_vel_z ||
        got.particle_index !== want.particle_index ||
        got.last_result !== want.last_result || got.overflow !== want.overflow) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch at %0t: expected pos %h %h %h vel %h %h %h idx %0d last %b ovf %b",
                 $time, want.new_pos_x, want.new_pos_y, want.new_pos_z, want.new_vel_x,
                 want.new_vel_y, want.new_vel_z, want.particle_index, want.last_result,
                 want.overflow);
        $display("                 actual   pos %h %h %h vel %h %h %h idx %0d last %b ovf %b",
                 got.new_pos_x, got.new_pos_y, got.new_pos_z, got.new_vel_x,
                 got.new_vel_y, got.new_vel_z, got.particle_index, got.last_result,
                 got.overflow);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= nbe_pkg::TIME_STEP_RST;
      eps_sq_q <= nbe_pkg::SOFTENING_SQ_RST;
      grav_q <= nbe_pkg::GRAV_CONSTANT_RST;
      body_count = 0;
      dropped = 0;
      fail_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          nbe_pkg::CFG_TIME_STEP: dt_q <= cfg_data_i;
          nbe_pkg::CFG_SOFTENING_SQ: eps_sq_q <= cfg_data_i;
          nbe_pkg::CFG_GRAV_CONSTANT: grav_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) compare_result(out_item_i);
      if (in_valid_i && in_ready_i) begin
        if (body_count < nbe_pkg::MAX_PARTICLES) begin
          mass_mem[body_count] = in_item_i.body_mass;
          pos_mem[body_count][0] = in_item_i.pos_x;
          pos_mem[body_count][1] = in_item_i.pos_y;
          pos_mem[body_count][2] = in_item_i.pos_z;
          vel_mem[body_count][0] = in_item_i.vel_x;
          vel_mem[body_count][1] = in_item_i.vel_y;
          vel_mem[body_count][2] = in_item_i.vel_z;
          body_count++;
        end else begin
          dropped = 1;
        end
        if (in_item_i.last_particle) predict_step();
      end
    end
  end
endmodule

>>> verif/direct_nbody_euler_step_core_tb.sv
module direct_nbody_euler_step_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [nbe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint CYCLE_LIMIT = 8000000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  nbe_pkg::nbe_in_t              in_item_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  nbe_pkg::nbe_out_t             out_item_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [nbe_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]                   cfg_data_i;
  int                            fail_count;
  int                            pending;
  int                            send_idle_pct;
  int                            recv_stall_pct;
  int                            hold_off;
  int                            items_sent;
  int                            fails_at_end;

  direct_nbody_euler_step_core u_top (.*);

  nbe_step_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    longint cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("direct_nbody_euler_step_core_tb: done, errors");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_body(nbe_pkg::nbe_in_t body);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i <= body;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic write_reg(logic [nbe_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int spread);
    case ($urandom_range(3))
      0: return $urandom;
      default: return $signed($urandom_range(2 * spread)) - spread;
    endcase
  endfunction

  function automatic nbe_pkg::nbe_in_t rand_body(bit last);
    nbe_pkg::nbe_in_t b;
    b.body_mass = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0008_0000);
    b.pos_x = rand_coord(32'h0020_0000);
    b.pos_y = rand_coord(32'h0020_0000);
    b.pos_z = rand_coord(32'h0020_0000);
    b.vel_x = rand_coord(32'h0004_0000);
    b.vel_y = rand_coord(32'h0004_0000);
    b.vel_z = rand_coord(32'h0004_0000);
    b.last_particle = last;
    return b;
  endfunction

  function automatic nbe_pkg::nbe_in_t make_body(logic [31:0] m, logic [31:0] px,
                                                 logic [31:0] py, logic [31:0] pz,
                                                 logic [31:0] v, bit last);
    nbe_pkg::nbe_in_t b;
    b.body_mass = m;
    b.pos_x = px;
    b.pos_y = py;
    b.pos_z = pz;
    b.vel_x = v;
    b.vel_y = ~v;
    b.vel_z = v;
    b.last_particle = last;
    return b;
  endfunction

  task automatic send_set(int count);
    for (int i = 0; i < count; i++) send_body(rand_body(i == count - 1));
  endtask

  task automatic random_phase(int item_goal);
    int start;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      if ($urandom_range(9) == 0) send_set($urandom_range(9, 14));
      else send_set($urandom_range(1, 6));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = nbe_pkg::CFG_TIME_STEP;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    items_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of every field, then a lone body.
    send_body(make_body(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 0));
    send_body(make_body(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                        32'h8000_0000, 0));
    send_body(make_body(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1));
    send_body(make_body(32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0000_1000, 1));
    // Coincident bodies, bodies closer than the resolution, and a tiny denominator.
    send_body(make_body(32'h0002_0000, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 0));
    send_body(make_body(32'h0002_0000, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 0));
    send_body(make_body(32'h0002_0000, 32'h0005_0001, 32'h0, 32'h0, 32'h0, 0));
    send_body(make_body(32'h0002_0000, 32'h0005_0100, 32'h0, 32'h0, 32'h0, 1));
    drain();

    write_reg(nbe_pkg::CFG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(nbe_pkg::CFG_SOFTENING_SQ, 32'hFFFF_FFFF);
    write_reg(nbe_pkg::CFG_GRAV_CONSTANT, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE, 32'h0);
    send_body(make_body(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 0));
    send_body(make_body(32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 0));
    send_body(make_body(32'h0000_0001, 32'h0, 32'h0000_0100, 32'h0, 32'h1234_5678, 1));
    drain();
    write_reg(nbe_pkg::CFG_TIME_STEP, 32'h0);
    write_reg(nbe_pkg::CFG_SOFTENING_SQ, 32'h0);
    write_reg(nbe_pkg::CFG_GRAV_CONSTANT, 32'h0);
    send_set(3);
    drain();

    // A full store with two loads dropped, the last of them closing the set.
    write_reg(nbe_pkg::CFG_TIME_STEP, 32'd656);
    write_reg(nbe_pkg::CFG_GRAV_CONSTANT, 32'h0001_0000);
    recv_stall_pct = 20;
    for (int i = 0; i < nbe_pkg::MAX_PARTICLES + 2; i++) begin
      send_body(rand_body(i == nbe_pkg::MAX_PARTICLES + 1));
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 63 : 23) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 63 : 23) : 0;
      write_reg(nbe_pkg::CFG_TIME_STEP,
                $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 4096));
      write_reg(nbe_pkg::CFG_SOFTENING_SQ,
                $urandom_range(1) ? $urandom_range(32'h0001_0000) : 32'h0);
      write_reg(nbe_pkg::CFG_GRAV_CONSTANT,
                $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0004_0000));
      if (phase == 2) begin
        send_set(4);
        hold_off = 4000;
        send_set(5);
        send_set(2);
      end
      random_phase(82);
      drain();
    end

    fails_at_end = fail_count;
    if (fails_at_end == 0) begin
      $display("direct_nbody_euler_step_core_tb: done, clean");
    end else begin
      $display("direct_nbody_euler_step_core_tb: done, errors");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/nbe_pkg.sv
design/nbe_ram.sv
design/nbe_isqrt.sv
design/nbe_div.sv
design/direct_nbody_euler_step_core.sv
verif/nbe_step_checker.sv
verif/direct_nbody_euler_step_core_tb.sv
